### src/gsq_pkg.sv
// gsq_pkg: shared types, constants and codes for the Gold sequence QPSK generator.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package gsq_pkg;

    // Default geometry of the generator
    localparam int PADDED_ELEMENTS = 32;
    localparam int USED_ELEMENTS   = 24;
    localparam int SEED_BITS       = 31;
    localparam int SYMBOL_COUNT    = 2;

    // Row layout: low half real plane, high half imaginary plane
    localparam int ROW_W   = 64;
    localparam int PLANE_W = 32;
    localparam int ELEM_W  = 5;
    localparam int CODE_W  = 16;

    // Half-precision codes for +1/sqrt2 and -1/sqrt2
    localparam logic [CODE_W-1:0] CODE_PLUS  = 16'h39A8;
    localparam logic [CODE_W-1:0] CODE_MINUS = 16'hB9A8;
    localparam logic [CODE_W-1:0] CODE_PAD   = 16'h0000;

    // Item mode codes
    localparam logic [1:0] MODE_ROW  = 2'd0;
    localparam logic [1:0] MODE_BASE = 2'd1;
    localparam logic [1:0] MODE_GEN  = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [4:0]       row_index;
        logic [ROW_W-1:0] row_bits;
        logic [30:0]      seed;
        logic             symbol_index;
    } gsq_item_t;

    typedef struct packed {
        logic              out_symbol;
        logic [ELEM_W-1:0] element_index;
        logic [CODE_W-1:0] real_code;
        logic [CODE_W-1:0] imag_code;
        logic              last;
    } gsq_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } gsq_state_t;

endpackage

`default_nettype wire

### src/gold_sequence_qpsk_gen.sv
// gold_sequence_qpsk_gen: top level of the Gold sequence QPSK generator.
// Instantiates gsq_ctrl, gsq_mem and gsq_out; uses gsq_pkg.
// Usage:
//   item channel (item_valid / item_stall / item): one beat per item.
//     Load-row and load-base items write the row store in the cycle they are
//     accepted and produce no result; out-of-range row indexes write nothing.
//     A generate item with a valid symbol index makes PADDED_ELEMENTS result
//     beats; mode 3 and out-of-range symbol indexes are accepted and dropped.
//   result channel (result_valid / result_stall / result): one beat per
//     element, element_index counting up, last set on the final element.
// Sequencing: a generate item sweeps the row store through its single read
//   port, one entry per cycle (base plus SEED_BITS rows), XOR-accumulating
//   the rows whose seed bit is set onto the base, then emits its elements
//   from the accumulated row, pausing while the output register is full.
//   Items are handled one at a time; item_stall is high from a generate
//   acceptance until its last element enters the output register.
// Reset: clears control state only; the row store is undefined until written.
// Receiver stall: the output register holds its beat, element sequencing
//   pauses, and no element is lost or repeated.
`default_nettype none

module gold_sequence_qpsk_gen #(
    parameter int SEED_BITS = gsq_pkg::SEED_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire gsq_pkg::gsq_item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output gsq_pkg::gsq_result_t      result
);
    import gsq_pkg::*;

    // Row store address: SEED_BITS matrix rows plus the base vector on top
    localparam int AW = $clog2(SEED_BITS + 1);

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [ROW_W-1:0] mem_rdata;
    logic             room;
    logic             push;
    gsq_result_t      push_data;

    gsq_ctrl #(
        .SEED_BITS (SEED_BITS),
        .AW        (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .room       (room),
        .push       (push),
        .push_data  (push_data)
    );

    // Matrix rows and base vector; registered read data
    gsq_mem #(
        .SEED_BITS (SEED_BITS),
        .AW        (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register parts the element sequencer from the receiver
    gsq_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### src/gsq_mem.sv
// gsq_mem: row store for the seed matrix plus the base vector in its top entry.
// One write port, one read port with registered read data; uses gsq_pkg.
`default_nettype none

module gsq_mem #(
    parameter int SEED_BITS = gsq_pkg::SEED_BITS,
    parameter int AW        = $clog2(SEED_BITS + 1)
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [gsq_pkg::ROW_W-1:0] wdata,
    input  wire logic                     re,
    input  wire logic [AW-1:0]            raddr,
    output logic      [gsq_pkg::ROW_W-1:0] rdata
);
    import gsq_pkg::*;

    localparam int DEPTH = SEED_BITS + 1;

    logic [ROW_W-1:0] row_mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            row_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= row_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/gsq_ctrl.sv
// gsq_ctrl: item intake, row-store writes, read sweep with XOR accumulation,
// and element sequencing. Uses gsq_pkg; drives gsq_mem and gsq_out.
`default_nettype none

module gsq_ctrl #(
    parameter int SEED_BITS = gsq_pkg::SEED_BITS,
    parameter int AW        = $clog2(SEED_BITS + 1)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire gsq_pkg::gsq_item_t        item,
    output logic                           mem_we,
    output logic      [AW-1:0]             mem_waddr,
    output logic      [gsq_pkg::ROW_W-1:0] mem_wdata,
    output logic                           mem_re,
    output logic      [AW-1:0]             mem_raddr,
    input  wire logic [gsq_pkg::ROW_W-1:0] mem_rdata,
    input  wire logic                      room,
    output logic                           push,
    output gsq_pkg::gsq_result_t           push_data
);
    import gsq_pkg::*;

    localparam logic [AW-1:0] BASE_ADDR = AW'(SEED_BITS);

    gsq_state_t           state_reg, state_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [SEED_BITS-1:0] seed_reg, seed_next;
    logic                 sym_reg, sym_next;
    logic [ROW_W-1:0]     acc_reg, acc_next;
    logic [ELEM_W-1:0]    el_reg, el_next;
    logic                 accept;
    logic                 used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        seed_reg <= seed_next;
        sym_reg  <= sym_next;
        acc_reg  <= acc_next;
        el_reg   <= el_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        seed_next  = seed_reg;
        sym_next   = sym_reg;
        acc_next   = acc_reg;
        el_next    = el_reg;
        mem_we     = 1'b0;
        mem_waddr  = BASE_ADDR;
        mem_wdata  = item.row_bits;
        mem_re     = 1'b0;
        mem_raddr  = BASE_ADDR;
        push       = 1'b0;
        item_stall = (state_reg != ST_IDLE);
        accept     = item_valid && !item_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.mode)
                        MODE_ROW:
                        begin
                            if (item.row_index < 5'(SEED_BITS))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(item.row_index);
                            end
                        end
                        MODE_BASE:
                        begin
                            mem_we = 1'b1;
                        end
                        MODE_GEN:
                        begin
                            // Start the sweep with the base vector read
                            if ({1'b0, item.symbol_index} < 2'(SYMBOL_COUNT))
                            begin
                                mem_re     = 1'b1;
                                idx_next   = '0;
                                seed_next  = item.seed[SEED_BITS-1:0];
                                sym_next   = item.symbol_index;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            // drop unused mode
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Data on mem_rdata belongs to entry idx_reg - 1, or base at 0
                if (idx_reg == '0)
                begin
                    acc_next = mem_rdata;
                end
                else
                begin
                    if (seed_reg[0])
                    begin
                        acc_next = acc_reg ^ mem_rdata;
                    end
                    seed_next = seed_reg >> 1;
                end
                if (idx_reg == AW'(SEED_BITS))
                begin
                    el_next    = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (room)
                begin
                    push = 1'b1;
                    if (el_reg == ELEM_W'(PADDED_ELEMENTS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        el_next = el_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Element payload from the accumulated row
    always_comb
    begin
        used = ({1'b0, el_reg} < 6'(USED_ELEMENTS));
        push_data.out_symbol    = sym_reg;
        push_data.element_index = el_reg;
        push_data.real_code     = !used ? CODE_PAD :
                                  (acc_reg[el_reg] ? CODE_MINUS : CODE_PLUS);
        push_data.imag_code     = !used ? CODE_PAD :
                                  (acc_reg[PLANE_W + int'(el_reg)] ? CODE_MINUS : CODE_PLUS);
        push_data.last          = (el_reg == ELEM_W'(PADDED_ELEMENTS - 1));
    end

endmodule

`default_nettype wire

### src/gsq_out.sv
// gsq_out: output register stage for result beats with valid/stall handshake.
// Uses gsq_pkg result type; fed by gsq_ctrl.
`default_nettype none

module gsq_out (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire gsq_pkg::gsq_result_t push_data,
    output logic                      room,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output gsq_pkg::gsq_result_t      result
);
    import gsq_pkg::*;

    logic        valid_reg;
    gsq_result_t data_reg;

    // Take a new beat when empty or when the held beat leaves this cycle
    assign room = !valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && push)
        begin
            data_reg <= push_data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

`default_nettype wire
